@@ src/swdh_pkg.sv @@
package swdh_pkg;

    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_TICK       = 2'd1,
        OP_LINE_RESET = 2'd2
    } opcode_t;

    localparam int DEFAULT_LINE_RESET_BITS = 64;

    localparam logic [2:0] ACK_OK = 3'b001;

    localparam int REQ_BITS      = 8;
    localparam int TURN_PHASE    = 8;
    localparam int ACK_FIRST     = 9;
    localparam int ACK_LAST      = 11;
    localparam int WR_TURN_PHASE = 12;
    localparam int DATA_LAST     = 44;
    localparam int RD_DATA_LAST  = 43;
    localparam int FINAL_PHASE   = 45;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic a3;
        logic a2;
        logic rd;
        logic ap;
    } op_flags_t;

endpackage

@@ src/swd_host_transfer_sequencer_unit.sv @@
// serial wire debug host transfer sequencer
//
// input channel (s_): one request per item. s_tuser carries the opcode: start transfer,
// clock tick or start line reset. a start request latches the transfer fields and gives
// no result. each tick request while a transfer or line reset is running clocks one wire
// bit: it samples dio_in and returns one result on the m_ channel with the level and
// enable the host drives during that bit, the ack bits so far, and on the final bit the
// received word and parity. m_tlast marks the final bit of a transfer or line reset.
// ticks while idle, starts while busy and unknown opcodes give no result.
//
// an accepted request has its result registered in the output register.
// a request can be taken every cycle; the state (bit phase counter, shift word, parity,
// ack bits and busy flag) is updated from each accepted request. when the receiver stalls with a result
// waiting, s_tready drops until the output register is taken; a request is still taken
// in the same cycle the waiting result leaves.
//
// aresetn (synchronous, active low) returns the block to idle with no result pending.
module swd_host_transfer_sequencer_unit #(
    parameter int LINE_RESET_BITS = swdh_pkg::DEFAULT_LINE_RESET_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // is_ap, is_read, reg_addr[1:0], write_data[31:0], ignore_ack, dio_in, zero fill
    input  logic [swdh_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // dio_out, dio_drive, ack_code[2:0], read_data[31:0], read_parity, status, zero fill
    output logic [swdh_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import swdh_pkg::*;

    localparam int PHASE_W = $clog2(LINE_RESET_BITS);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               busy_reg, busy_next;
    logic [31:0]        shift_reg, shift_next;
    logic               parity_reg, parity_next;
    logic [2:0]         ack_reg, ack_next;
    op_flags_t          flags_reg, flags_next;
    logic               ign_reg, ign_next;
    logic               lreset_reg, lreset_next;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;

    opcode_t     opcode;
    logic        in_is_ap, in_is_read, in_ignore, in_dio;
    logic [1:0]  in_addr;
    logic [31:0] in_wdata;
    logic        in_acc;
    logic        fire;
    logic        dout, drv, status, last, rpar;
    logic [31:0] rdata;
    logic [2:0]  ack_out;
    logic [1:0]  ack_idx;

    assign opcode     = opcode_t'(s_tuser);
    assign in_is_ap   = s_tdata[0];
    assign in_is_read = s_tdata[1];
    assign in_addr    = s_tdata[3:2];
    assign in_wdata   = s_tdata[35:4];
    assign in_ignore  = s_tdata[36];
    assign in_dio     = s_tdata[37];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign ack_idx  = 2'(phase_reg - PHASE_W'(ACK_FIRST));

    always_comb begin
        phase_next  = phase_reg;
        busy_next   = busy_reg;
        shift_next  = shift_reg;
        parity_next = parity_reg;
        ack_next    = ack_reg;
        flags_next  = flags_reg;
        ign_next    = ign_reg;
        lreset_next = lreset_reg;
        fire    = 1'b0;
        dout    = 1'b0;
        drv     = 1'b0;
        status  = 1'b0;
        last    = 1'b0;
        rpar    = 1'b0;
        rdata   = '0;
        ack_out = '0;
        if (in_acc) begin
            case (opcode)
                OP_START, OP_LINE_RESET: begin
                    if (!busy_reg) begin
                        busy_next   = 1'b1;
                        phase_next  = '0;
                        ack_next    = '0;
                        parity_next = 1'b0;
                        if (opcode == OP_LINE_RESET) begin
                            lreset_next = 1'b1;
                            shift_next  = '0;
                            flags_next  = '0;
                            ign_next    = 1'b0;
                        end else begin
                            lreset_next = 1'b0;
                            flags_next  = '{a3: in_addr[1], a2: in_addr[0],
                                            rd: in_is_read, ap: in_is_ap};
                            shift_next  = in_wdata;
                            ign_next    = in_ignore;
                        end
                    end
                end
                OP_TICK: begin
                    if (busy_reg) begin
                        fire = 1'b1;
                        if (lreset_reg) begin
                            dout = 1'b1;
                            drv  = 1'b1;
                            last = (phase_reg == PHASE_W'(LINE_RESET_BITS - 1));
                        end else begin
                            if (phase_reg < PHASE_W'(REQ_BITS)) begin
                                drv = 1'b1;
                                case (phase_reg[2:0])
                                    3'd0:    dout = 1'b1;
                                    3'd1:    dout = flags_reg.ap;
                                    3'd2:    dout = flags_reg.rd;
                                    3'd3:    dout = flags_reg.a2;
                                    3'd4:    dout = flags_reg.a3;
                                    3'd5:    dout = ^flags_reg;
                                    3'd6:    dout = 1'b0;
                                    default: dout = 1'b1;
                                endcase
                            end else if (phase_reg == PHASE_W'(TURN_PHASE)) begin
                                // released turnaround
                            end else if (phase_reg <= PHASE_W'(ACK_LAST)) begin
                                ack_next = ack_reg | (3'(in_dio) << ack_idx);
                                if (phase_reg == PHASE_W'(ACK_LAST) && flags_reg.rd
                                        && ack_next != ACK_OK) begin
                                    status = 1'b1;
                                    last   = 1'b1;
                                end
                            end else if (flags_reg.rd) begin
                                if (phase_reg <= PHASE_W'(RD_DATA_LAST)) begin
                                    shift_next = {in_dio, shift_reg[31:1]};
                                end else if (phase_reg == PHASE_W'(DATA_LAST)) begin
                                    parity_next = in_dio;
                                end else begin
                                    drv   = 1'b1;
                                    last  = 1'b1;
                                    rdata = shift_reg;
                                    rpar  = parity_reg;
                                end
                            end else begin
                                drv = 1'b1;
                                if (phase_reg == PHASE_W'(WR_TURN_PHASE)) begin
                                    if (ack_reg != ACK_OK && !ign_reg) begin
                                        status = 1'b1;
                                        last   = 1'b1;
                                    end
                                end else if (phase_reg <= PHASE_W'(DATA_LAST)) begin
                                    dout        = shift_reg[0];
                                    parity_next = parity_reg ^ shift_reg[0];
                                    shift_next  = {1'b0, shift_reg[31:1]};
                                end else begin
                                    dout = parity_reg;
                                    last = 1'b1;
                                end
                            end
                            ack_out = ack_next;
                        end
                        phase_next = phase_reg + 1'b1;
                        if (last) begin
                            busy_next  = 1'b0;
                            phase_next = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            busy_reg     <= 1'b0;
            shift_reg    <= '0;
            parity_reg   <= 1'b0;
            ack_reg      <= '0;
            flags_reg    <= '0;
            ign_reg      <= 1'b0;
            lreset_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            busy_reg   <= busy_next;
            shift_reg  <= shift_next;
            parity_reg <= parity_next;
            ack_reg    <= ack_next;
            flags_reg  <= flags_next;
            ign_reg    <= ign_next;
            lreset_reg <= lreset_next;
            if (in_acc) begin
                m_tvalid_reg <= fire;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {1'b0, status, rpar, rdata, ack_out, drv, dout};
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_last_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> !busy_reg)
        else $error("final bit shown while still busy");

    a_fault_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[38] |-> m_tlast_reg)
        else $error("ack fault without end of transfer");

    a_idle_phase : assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> phase_reg == '0)
        else $error("phase counter not cleared while idle");

    a_xfer_phase : assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !lreset_reg |-> phase_reg <= PHASE_W'(FINAL_PHASE))
        else $error("transfer phase beyond final bit");

endmodule
